// ===== rtl/core/cmi_pkg.sv =====
// Package for the complex magnitude block: widths, stage counts, types and the
// square-root step function. No dependencies.
package cmi_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int FIELD_W      = 16;
	localparam int MAG_W        = 16;

	// a^2 + b^2 <= 2^(2*SAMPLE_WIDTH-1), so the energy fits in 2*SAMPLE_WIDTH bits
	localparam int ENERGY_W = 2 * SAMPLE_WIDTH;
	localparam int ROOT_W   = SAMPLE_WIDTH;
	localparam int REM_W    = ROOT_W + 2;

	// two root bits resolved per register stage
	localparam int SQRT_STAGES = (ROOT_W + 1) / 2;
	localparam int STEPS       = 2 * SQRT_STAGES;
	localparam int NUM_W       = 2 * STEPS;

	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} step_t;

	// One restoring digit step: bring down two energy bits, try root*4+1.
	function automatic step_t sqrt_step(step_t cur, logic [1:0] pair);
		logic [REM_W+1:0] rem_new;
		logic [REM_W+1:0] trial;
		step_t            nxt;
		rem_new = {cur.rem, pair};
		trial   = (REM_W+2)'({cur.root, 2'b01});
		if (rem_new >= trial) begin
			nxt.rem  = REM_W'(rem_new - trial);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_W'(rem_new);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// ===== rtl/core/complex_magnitude_isqrt.sv =====
// Top level: complex sample magnitude, floor(sqrt(re^2 + im^2)).
// Depends on cmi_pkg, cmi_energy, cmi_sqrt.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------
//  input   | in_valid / in_stall  | re_part, im_part, last_in
//  output  | out_valid / out_stall| magnitude, last_out
//
// One transaction per clock unless the output stalls. The path has three
// energy stages, the square-root stages at two root bits each, and the
// output register. Reset clears the valid bits and the inner last tags only.
// A stall on the output freezes the whole pipeline and is returned as in_stall
// in the same cycle, only while the output register holds a transaction.
module complex_magnitude_isqrt import cmi_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [FIELD_W-1:0] re_part,
	input  logic signed [FIELD_W-1:0] im_part,
	input  logic                      last_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [MAG_W-1:0]          magnitude,
	output logic                      last_out
);

	logic                en;
	tag_t                in_tag, en_tag, sq_tag;
	logic [ENERGY_W-1:0] energy;
	logic [ROOT_W-1:0]   root;
	logic [MAG_W-1:0]    mag_sat;

	logic                out_vld_q;
	logic                last_q;
	logic [MAG_W-1:0]    mag_q;

	assign en       = !(out_vld_q && out_stall);
	assign in_stall = !en;
	assign in_tag   = '{valid: in_valid, last: last_in};

	cmi_energy u_energy (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (in_tag),
		.re_part (re_part),
		.im_part (im_part),
		.out_tag (en_tag),
		.energy  (energy)
	);

	cmi_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (en_tag),
		.energy  (energy),
		.out_tag (sq_tag),
		.root    (root)
	);

	// wide samples can give a root above the output width
	if (ROOT_W > MAG_W) begin : g_sat
		assign mag_sat = (|root[ROOT_W-1:MAG_W]) ? MAG_MAX : root[MAG_W-1:0];
	end else begin : g_nosat
		assign mag_sat = MAG_W'(root);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= sq_tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q  <= mag_sat;
			last_q <= sq_tag.last;
		end
	end

	assign out_valid = out_vld_q;
	assign magnitude = mag_q;
	assign last_out  = last_q;

	// backpressure only comes from a held output transaction
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output transaction");

	// an empty output register never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input blocked while output is free");

endmodule

// ===== rtl/core/cmi_energy.sv =====
// Energy front end: absolute value, squares, sum over three register stages.
// Depends on cmi_pkg.
module cmi_energy import cmi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  tag_t                    in_tag,
	input  logic signed [FIELD_W-1:0] re_part,
	input  logic signed [FIELD_W-1:0] im_part,
	output tag_t                    out_tag,
	output logic [ENERGY_W-1:0]     energy
);

	logic [SAMPLE_WIDTH-1:0] re_raw, im_raw;
	logic [SAMPLE_WIDTH-1:0] re_abs, im_abs;

	tag_t                    tag_s1, tag_s2, tag_s3;
	logic [SAMPLE_WIDTH-1:0] re_abs_s1, im_abs_s1;
	logic [ENERGY_W-1:0]     re_sq_s2, im_sq_s2;
	logic [ENERGY_W-1:0]     energy_s3;

	// low SAMPLE_WIDTH bits of each field, sign bit at SAMPLE_WIDTH-1
	assign re_raw = SAMPLE_WIDTH'($unsigned(re_part));
	assign im_raw = SAMPLE_WIDTH'($unsigned(im_part));
	// most negative value maps to 2^(SAMPLE_WIDTH-1), still fits unsigned
	assign re_abs = re_raw[SAMPLE_WIDTH-1] ? (~re_raw + 1'b1) : re_raw;
	assign im_abs = im_raw[SAMPLE_WIDTH-1] ? (~im_raw + 1'b1) : im_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_abs_s1 <= re_abs;
			im_abs_s1 <= im_abs;
			re_sq_s2  <= ENERGY_W'(re_abs_s1) * ENERGY_W'(re_abs_s1);
			im_sq_s2  <= ENERGY_W'(im_abs_s1) * ENERGY_W'(im_abs_s1);
			energy_s3 <= re_sq_s2 + im_sq_s2;
		end
	end

	assign out_tag = tag_s3;
	assign energy  = energy_s3;

endmodule

// ===== rtl/core/cmi_sqrt.sv =====
// Pipelined floor square root, two result bits per register stage.
// Depends on cmi_pkg.
module cmi_sqrt import cmi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  tag_t                in_tag,
	input  logic [ENERGY_W-1:0] energy,
	output tag_t                out_tag,
	output logic [ROOT_W-1:0]   root
);

	tag_t             tag_s  [SQRT_STAGES];
	step_t            step_s [SQRT_STAGES];
	logic [NUM_W-1:0] num_s  [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam int P_HI = STEPS - 1 - 2 * k;
		localparam int P_LO = P_HI - 1;

		tag_t             tag_in;
		step_t            st_in;
		step_t            st_mid;
		step_t            st_out;
		logic [NUM_W-1:0] num_in;

		if (k == 0) begin : g_first
			assign tag_in = in_tag;
			assign st_in  = '0;
			assign num_in = NUM_W'(energy);
		end else begin : g_next
			assign tag_in = tag_s[k-1];
			assign st_in  = step_s[k-1];
			assign num_in = num_s[k-1];
		end

		assign st_mid = sqrt_step(st_in, num_in[2*P_HI +: 2]);
		assign st_out = sqrt_step(st_mid, num_in[2*P_LO +: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= tag_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_s[k] <= st_out;
				num_s[k]  <= num_in;
			end
		end
	end

	assign out_tag = tag_s[SQRT_STAGES-1];
	assign root    = step_s[SQRT_STAGES-1].root;

endmodule

// ===== tb/sv/cmi_checker.sv =====
// Checker for complex_magnitude_isqrt: watches both channels, predicts the
// floor magnitude of each accepted sample and compares it with the output.
// Depends on cmi_pkg.
`timescale 1ns / 100ps

module cmi_checker import cmi_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [FIELD_W-1:0] re_part,
	input  logic signed [FIELD_W-1:0] im_part,
	input  logic                      last_in,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [MAG_W-1:0]          magnitude,
	input  logic                      last_out,
	output int                        fail_count,
	output int                        outstanding
);

	typedef struct {
		logic [MAG_W-1:0] mag;
		logic             last;
	} mag_result_t;

	mag_result_t mag_fifo[$];
	int          errors = 0;

	// Low SAMPLE_WIDTH bits of each part, sign-extended, then floor sqrt of
	// the energy, found bit by bit from the top; saturates to MAG_MAX.
	function automatic logic [MAG_W-1:0] isqrt_magnitude(logic [FIELD_W-1:0] re,
			logic [FIELD_W-1:0] im);
		longint      sr;
		longint      si;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] energy;
		logic [63:0] root;
		logic [63:0] trial;
		sr = longint'($signed(re[SAMPLE_WIDTH-1:0]));
		si = longint'($signed(im[SAMPLE_WIDTH-1:0]));
		a = (sr < 0) ? 64'(-sr) : 64'(sr);
		b = (si < 0) ? 64'(-si) : 64'(si);
		energy = a * a + b * b;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= energy)
				root = trial;
		end
		if (root > 64'(MAG_MAX))
			return MAG_MAX;
		return root[MAG_W-1:0];
	endfunction

	always @(posedge clk) begin
		mag_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want.mag  = isqrt_magnitude(re_part, im_part);
				want.last = last_in;
				mag_fifo.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (mag_fifo.size() == 0) begin
					$error("unexpected transaction: magnitude %0d last_out %0b",
						magnitude, last_out);
					errors++;
				end else begin
					want = mag_fifo.pop_front();
					if (magnitude !== want.mag) begin
						$error("magnitude: expected %0d, got %0d", want.mag, magnitude);
						errors++;
					end
					if (last_out !== want.last) begin
						$error("last_out: expected %0b, got %0b", want.last, last_out);
						errors++;
					end
				end
			end
		end
		fail_count  <= errors;
		outstanding <= mag_fifo.size();
	end

endmodule

// ===== tb/sv/tb_complex_magnitude_isqrt.sv =====
// Testbench top for complex_magnitude_isqrt: clock, reset, sample stimulus
// and output stalls; checking is done by cmi_checker. Depends on cmi_pkg.
`timescale 1ns / 100ps

module tb_complex_magnitude_isqrt import cmi_pkg::*; ();

	localparam int RANDOM_PER_PHASE = 400;
	localparam int HOLD_CYCLES      = 200;
	localparam int DRAIN_CYCLES     = 20;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic signed [FIELD_W-1:0] re_part   = '0;
	logic signed [FIELD_W-1:0] im_part   = '0;
	logic                      last_in   = 1'b0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [MAG_W-1:0]          magnitude;
	logic                      last_out;
	int                        fail_count;
	int                        outstanding;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	bit hold_request = 1'b0;
	bit hold_done    = 1'b0;

	complex_magnitude_isqrt uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.re_part   (re_part),
		.im_part   (im_part),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.magnitude (magnitude),
		.last_out  (last_out)
	);

	cmi_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.re_part     (re_part),
		.im_part     (im_part),
		.last_in     (last_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.magnitude   (magnitude),
		.last_out    (last_out),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver: random stalls, or one long hold-off when requested.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done && hold_left == 0)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
				if (hold_left == 0)
					hold_done = 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer_sample(logic [FIELD_W-1:0] re, logic [FIELD_W-1:0] im, logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		re_part  <= re;
		im_part  <= im;
		last_in  <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Mix of full-range, small, extreme and near-axis parts.
	function automatic logic [FIELD_W-1:0] pick_part();
		case ($urandom_range(4))
			0: return FIELD_W'($urandom_range(64)) - FIELD_W'(32);
			1: begin
				case ($urandom_range(3))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh8001;
					default: return '0;
				endcase
			end
			2: return FIELD_W'($urandom_range(255)) << $urandom_range(8);
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			offer_sample(pick_part(), pick_part(), 1'($urandom_range(1)));
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners
		offer_sample(16'sd0, 16'sd0, 1'b0);
		offer_sample(16'sd1, 16'sd0, 1'b1);
		offer_sample(-16'sd1, -16'sd1, 1'b0);
		offer_sample(16'sd3, 16'sd4, 1'b0);
		offer_sample(-16'sd5, 16'sd12, 1'b1);
		offer_sample(16'sd6, -16'sd12, 1'b0);
		offer_sample(16'sd32767, 16'sd0, 1'b0);
		offer_sample(16'sh8000, 16'sd0, 1'b1);
		offer_sample(16'sd0, 16'sh8000, 1'b0);
		offer_sample(16'sd32767, 16'sd32767, 1'b0);
		offer_sample(16'sh8000, 16'sh8000, 1'b1);   // energy 2^31, unsigned
		offer_sample(16'sd32767, 16'sh8000, 1'b0);
		offer_sample(16'sh8001, 16'sh8001, 1'b1);
		offer_sample(16'sd255, 16'sd256, 1'b0);
		offer_sample(16'sd181, 16'sd181, 1'b1);
		offer_sample(16'sh5555, 16'shAAAA, 1'b0);
		offer_sample(16'shAAAA, 16'sh5555, 1'b1);

		tx_idle_pct  = 29;
		rx_stall_pct = 88;
		random_phase(RANDOM_PER_PHASE);

		tx_idle_pct  = 88;
		rx_stall_pct = 29;
		random_phase(RANDOM_PER_PHASE);

		// back-to-back with a long output hold-off to fill the pipeline
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_request = 1'b1;
		random_phase(RANDOM_PER_PHASE);
		in_valid <= 1'b0;

		while (outstanding != 0 || !hold_done)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/cmi_pkg.sv
rtl/core/cmi_energy.sv
rtl/core/cmi_sqrt.sv
rtl/core/complex_magnitude_isqrt.sv
tb/sv/cmi_checker.sv
tb/sv/tb_complex_magnitude_isqrt.sv
